// ----- rtl/gqcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and structs of the GF(2) quadratic candidate filter.
// No dependencies.
package gqcf_pkg;

    localparam int MAX_VARS      = 32;
    localparam int NUM_EQUATIONS = 16;
    localparam int BATCH_SIZE    = 32;

    localparam int VAR_W  = 5;   // index of one variable
    localparam int CNT_W  = 6;   // counts up to 32
    localparam int CAND_W = 32;
    localparam int COEF_W = 16;

    typedef enum logic [1:0] {
        OP_LIN  = 2'd0,
        OP_QUAD = 2'd1,
        OP_CAND = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic {
        REG_NUM_VARS = 1'b0,
        REG_MAX_KEPT = 1'b1
    } t_reg_index;

    // Candidate moving along the cell chain with its partial equation word
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [CAND_W-1:0]        cand;
        logic [NUM_EQUATIONS-1:0] eq;
    } t_stage;

    // Coefficient write broadcast to every cell
    typedef struct packed {
        logic                     wr_lin;
        logic                     wr_quad;
        logic [VAR_W-1:0]         sel;
        logic [VAR_W-1:0]         var_low;
        logic [NUM_EQUATIONS-1:0] coef;
    } t_load;

endpackage
`default_nettype wire

// ----- rtl/gqcf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces: input items, result items and configuration writes.
// No dependencies.
interface gqcf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  var_high;
    logic [4:0]  var_low;
    logic [15:0] coef_word;
    logic [31:0] candidate;
    logic        last_of_batch;
    modport source (output valid, opcode, var_high, var_low, coef_word, candidate,
                    last_of_batch, input ready);
    modport sink (input valid, opcode, var_high, var_low, coef_word, candidate,
                  last_of_batch, output ready);
endinterface

interface gqcf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] candidate_out;
    logic        kept;
    logic [5:0]  kept_count;
    logic        batch_end;
    logic        dropped;
    modport source (output valid, candidate_out, kept, kept_count, batch_end, dropped,
                    input ready);
    modport sink (input valid, candidate_out, kept, kept_count, batch_end, dropped,
                  output ready);
endinterface

interface gqcf_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [5:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/gqcf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One variable's cell: holds its linear word and its quadratic words against
// all smaller variables, and folds them into the passing candidate. Uses gqcf_pkg.
module gqcf_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  wire [gqcf_pkg::VAR_W-1:0]   i_idx,
    input  wire [gqcf_pkg::CNT_W-1:0]   i_num_vars,
    input  wire gqcf_pkg::t_load        i_load,
    input  wire gqcf_pkg::t_stage       i_stage,
    output gqcf_pkg::t_stage            o_stage
);
    logic [gqcf_pkg::NUM_EQUATIONS-1:0] r_lin;
    logic [gqcf_pkg::NUM_EQUATIONS-1:0] r_quad [gqcf_pkg::MAX_VARS-1];
    gqcf_pkg::t_stage r_stage;
    gqcf_pkg::t_stage n_stage;
    logic [gqcf_pkg::NUM_EQUATIONS-1:0] w_term;
    logic w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= '0;
            for (int k = 0; k < gqcf_pkg::MAX_VARS - 1; k++) begin
                r_quad[k] <= '0;
            end
        end else begin
            if (i_load.wr_lin && i_load.sel == i_idx) begin
                r_lin <= i_load.coef;
            end
            if (i_load.wr_quad && i_load.sel == i_idx && i_load.var_low < i_idx) begin
                r_quad[i_load.var_low] <= i_load.coef;
            end
        end
    end

    // Sum of this variable's terms for the bits set in the candidate
    always_comb begin
        w_active = ({1'b0, i_idx} < i_num_vars) && i_stage.cand[i_idx];
        w_term   = r_lin;
        for (int k = 0; k < gqcf_pkg::MAX_VARS - 1; k++) begin
            if (k < 32'(i_idx) && i_stage.cand[k]) begin
                w_term = w_term ^ r_quad[k];
            end
        end
        n_stage = i_stage;
        if (w_active) begin
            n_stage.eq = i_stage.eq ^ w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_adv) begin
            r_stage.last <= n_stage.last;
            r_stage.cand <= n_stage.cand;
            r_stage.eq   <= n_stage.eq;
        end
    end

    assign o_stage = r_stage;
endmodule
`default_nettype wire

// ----- rtl/gf2_quadratic_candidate_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the GF(2) quadratic candidate filter: cell chain and batch logic.
// Depends on gqcf_pkg, gqcf_if and gqcf_cell.
//
// Candidates enter a chain of 32 cells, one per variable, at one transaction
// per cycle while the output is not held up; each cell holds that variable's
// linear word and its quadratic words against smaller variables and XORs them
// into the candidate's running equation word as it passes. A taken candidate
// is captured by the first cell, passes the 31 further cell stages, then the
// output register, and the chain stalls as a whole while a finished result
// waits. Coefficient loads are only accepted once the chain holds no
// candidate, so a load that follows candidates waits until they have left
// the cells. Batch counting, the kept limit and the drop of candidates past
// 32 per batch are settled at the chain's tail in arrival order. Reset
// zeroes all coefficients; configuration writes are always accepted and
// should be issued only while the block is idle.
module gf2_quadratic_candidate_filter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    gqcf_in_if.sink     i_cand_if,
    gqcf_out_if.source  o_res_if,
    gqcf_cfg_if.sink    i_cfg_if
);
    localparam int NV = gqcf_pkg::MAX_VARS;

    logic [gqcf_pkg::CNT_W-1:0] r_num_vars, r_max_kept, w_nv_eff;
    logic [gqcf_pkg::CNT_W-1:0] r_pos, r_kept_cnt;
    logic [gqcf_pkg::NUM_EQUATIONS-1:0] r_lin0;
    gqcf_pkg::t_stage w_stage [NV+1];
    gqcf_pkg::t_load  w_load;
    logic [NV-1:0] w_busy;
    logic w_adv, w_accept, w_is_cand, w_is_load;
    logic w_drop, w_keep;
    gqcf_pkg::t_opcode w_op;

    logic        r_out_valid, r_kept, r_end, r_drop;
    logic [31:0] r_cand_out;
    logic [gqcf_pkg::CNT_W-1:0] r_cnt_out;

    // Configuration: always ready, write on handshake
    assign i_cfg_if.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= gqcf_pkg::CNT_W'(gqcf_pkg::MAX_VARS);
            r_max_kept <= gqcf_pkg::CNT_W'(gqcf_pkg::BATCH_SIZE);
        end else if (i_cfg_if.valid) begin
            case (gqcf_pkg::t_reg_index'(i_cfg_if.index))
                gqcf_pkg::REG_NUM_VARS: r_num_vars <= i_cfg_if.data;
                gqcf_pkg::REG_MAX_KEPT: r_max_kept <= i_cfg_if.data;
                default: ;
            endcase
        end
    end
    assign w_nv_eff = (r_num_vars > gqcf_pkg::CNT_W'(NV)) ? gqcf_pkg::CNT_W'(NV) : r_num_vars;

    // Advance the chain unless a result is held up at the output
    assign w_adv = !r_out_valid || o_res_if.ready;
    assign w_op  = gqcf_pkg::t_opcode'(i_cand_if.opcode);
    assign w_is_cand = (w_op == gqcf_pkg::OP_CAND);
    assign w_is_load = (w_op == gqcf_pkg::OP_LIN) || (w_op == gqcf_pkg::OP_QUAD);

    // Hold loads back until no candidate is in flight
    assign i_cand_if.ready = w_adv && (!w_is_load || (w_busy == '0));
    assign w_accept = i_cand_if.valid && i_cand_if.ready;

    always_comb begin
        w_load = '0;
        w_load.var_low = i_cand_if.var_low;
        w_load.coef    = i_cand_if.coef_word;
        w_load.sel     = i_cand_if.var_high[gqcf_pkg::VAR_W-1:0];
        if (w_accept && w_op == gqcf_pkg::OP_LIN) begin
            // linear word for variable v sits in cell v
            w_load.wr_lin = (i_cand_if.var_high != '0) &&
                            (i_cand_if.var_high <= gqcf_pkg::CNT_W'(NV));
            w_load.sel    = gqcf_pkg::VAR_W'(i_cand_if.var_high - 6'd1);
        end
        if (w_accept && w_op == gqcf_pkg::OP_QUAD) begin
            w_load.wr_quad = (i_cand_if.var_high < gqcf_pkg::CNT_W'(NV)) &&
                             ({1'b0, i_cand_if.var_low} < i_cand_if.var_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin0 <= '0;
        end else if (w_accept && w_op == gqcf_pkg::OP_LIN && i_cand_if.var_high == '0) begin
            r_lin0 <= i_cand_if.coef_word;
        end
    end

    // Inject: the constant term seeds the equation word
    always_comb begin
        w_stage[0].valid = w_accept && w_is_cand;
        w_stage[0].last  = i_cand_if.last_of_batch;
        w_stage[0].cand  = i_cand_if.candidate;
        w_stage[0].eq    = r_lin0;
    end

    for (genvar g = 0; g < NV; g++) begin : g_cell
        gqcf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_idx      (gqcf_pkg::VAR_W'(g)),
            .i_num_vars (w_nv_eff),
            .i_load     (w_load),
            .i_stage    (w_stage[g]),
            .o_stage    (w_stage[g+1])
        );
        assign w_busy[g] = w_stage[g+1].valid;
    end

    // Tail: batch position, kept limit and drop, in arrival order
    assign w_drop = r_pos >= gqcf_pkg::CNT_W'(gqcf_pkg::BATCH_SIZE);
    assign w_keep = !w_drop && (r_kept_cnt < r_max_kept) && (w_stage[NV].eq == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_kept_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_stage[NV].valid;
            if (w_stage[NV].valid) begin
                if (w_stage[NV].last) begin
                    r_pos      <= '0;
                    r_kept_cnt <= '0;
                end else begin
                    if (!w_drop) r_pos <= r_pos + 6'd1;
                    if (w_keep)  r_kept_cnt <= r_kept_cnt + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cand_out <= w_stage[NV].cand;
            r_kept     <= w_keep;
            r_cnt_out  <= r_kept_cnt + (w_keep ? 6'd1 : 6'd0);
            r_end      <= w_stage[NV].last;
            r_drop     <= w_drop;
        end
    end

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.candidate_out = r_cand_out;
    assign o_res_if.kept          = r_kept;
    assign o_res_if.kept_count    = r_cnt_out;
    assign o_res_if.batch_end     = r_end;
    assign o_res_if.dropped       = r_drop;

    a_keep_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid |-> !(o_res_if.kept && o_res_if.dropped))
        else $error("kept and dropped together");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_cnt <= r_pos && r_pos <= gqcf_pkg::CNT_W'(gqcf_pkg::BATCH_SIZE))
        else $error("batch counters out of range");
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_load) |-> (w_busy == '0))
        else $error("load accepted with candidates in flight");
    a_kept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.kept) |-> (o_res_if.kept_count != '0))
        else $error("kept with zero count");
endmodule
`default_nettype wire

// ----- tb/gqcf_tb_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the GF(2) quadratic candidate filter: tracks the channels,
// predicts each candidate's result and compares. Depends on gqcf_pkg and gqcf_if.
module gqcf_tb_checker
    import gqcf_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    gqcf_in_if     cand_if,
    gqcf_out_if    res_if,
    gqcf_cfg_if    cfg_if,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_results_seen,
    output int     o_kept_seen
);

    typedef struct {
        logic [CAND_W-1:0] cand;
        logic              kept;
        logic [CNT_W-1:0]  kept_count;
        logic              batch_end;
        logic              dropped;
    } t_filter_result;

    logic [COEF_W-1:0] lin_word [0:MAX_VARS];
    logic [COEF_W-1:0] quad_word [0:MAX_VARS*(MAX_VARS-1)/2-1];
    logic [CNT_W-1:0]  model_num_vars, model_max_kept, model_pos, model_kept;
    t_filter_result    expected_results [$];

    assign o_pending = expected_results.size();

    // Evaluate all equations on the candidate; zero word means it passes
    function automatic logic [COEF_W-1:0] equation_word(logic [CAND_W-1:0] c);
        logic [COEF_W-1:0] y;
        int n;
        y = lin_word[0];
        n = (model_num_vars > MAX_VARS) ? MAX_VARS : model_num_vars;
        for (int j = 0; j < n; j++) begin
            if (c[j]) begin
                y ^= lin_word[j+1];
                for (int k = 0; k < j; k++)
                    if (c[k]) y ^= quad_word[j*(j-1)/2 + k];
            end
        end
        return y;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_filter_result r, e;
        if (!i_rst_n) begin
            foreach (lin_word[i]) lin_word[i] = '0;
            foreach (quad_word[i]) quad_word[i] = '0;
            model_num_vars = 6'd32;
            model_max_kept = 6'd32;
            model_pos = '0;
            model_kept = '0;
            expected_results.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_kept_seen <= 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == REG_NUM_VARS) model_num_vars = cfg_if.data;
                else model_max_kept = cfg_if.data;
            end
            if (cand_if.valid && cand_if.ready) begin
                case (t_opcode'(cand_if.opcode))
                    OP_LIN: begin
                        if (cand_if.var_high <= MAX_VARS)
                            lin_word[cand_if.var_high] = cand_if.coef_word;
                    end
                    OP_QUAD: begin
                        if (cand_if.var_low < cand_if.var_high && cand_if.var_high < MAX_VARS)
                            quad_word[cand_if.var_high*(cand_if.var_high-1)/2
                                      + cand_if.var_low] = cand_if.coef_word;
                    end
                    OP_CAND: begin
                        r.cand = cand_if.candidate;
                        r.kept = 1'b0;
                        r.dropped = 1'b0;
                        if (model_pos >= BATCH_SIZE) begin
                            r.dropped = 1'b1;
                        end else begin
                            model_pos++;
                            if (model_kept < model_max_kept
                                && equation_word(cand_if.candidate) == '0) begin
                                model_kept++;
                                r.kept = 1'b1;
                            end
                        end
                        r.kept_count = model_kept;
                        r.batch_end = cand_if.last_of_batch;
                        expected_results.push_back(r);
                        if (cand_if.last_of_batch) begin
                            model_pos = '0;
                            model_kept = '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (res_if.valid && res_if.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (res_if.kept) o_kept_seen <= o_kept_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", res_if.candidate_out, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (res_if.candidate_out !== e.cand)
                        report_mismatch("candidate_out", res_if.candidate_out, e.cand);
                    if (res_if.kept !== e.kept)
                        report_mismatch("kept", res_if.kept, e.kept);
                    if (res_if.kept_count !== e.kept_count)
                        report_mismatch("kept_count", res_if.kept_count, e.kept_count);
                    if (res_if.batch_end !== e.batch_end)
                        report_mismatch("batch_end", res_if.batch_end, e.batch_end);
                    if (res_if.dropped !== e.dropped)
                        report_mismatch("dropped", res_if.dropped, e.dropped);
                end
            end
        end
    end

endmodule

// ----- tb/gf2_quadratic_candidate_filter_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the GF(2) quadratic candidate filter: drives loads,
// candidates and register writes, and gives the verdict. Depends on gqcf_pkg,
// gqcf_if, gqcf_tb_checker and the block itself.
module gf2_quadratic_candidate_filter_tb;
    import gqcf_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, results_seen, kept_seen;
    bit   idle_in_enable, idle_out_enable;
    bit   hold_off;
    int   items_sent;

    gqcf_in_if  cand_if ();
    gqcf_out_if res_if ();
    gqcf_cfg_if cfg_if ();

    gf2_quadratic_candidate_filter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand_if(cand_if.sink),
        .o_res_if (res_if.source),
        .i_cfg_if (cfg_if.sink)
    );

    gqcf_tb_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cand_if       (cand_if),
        .res_if        (res_if),
        .cfg_if        (cfg_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen),
        .o_kept_seen   (kept_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: well above the slowest legal run
    initial begin
        #(12ns * 400000);
        $display("timeout waiting for the block");
        $display("gf2_quadratic_candidate_filter_tb NOT OK");
        $finish;
    end

    // Receiver: random stalls, and one long hold-off when asked
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) res_if.ready <= 1'b0;
            else res_if.ready <= !(idle_out_enable && $urandom_range(99) < 16);
        end
    end

    // Offer one item and hold it until taken; a random gap may come first
    task automatic send_item(t_opcode op, logic [31:0] vh, logic [31:0] vl,
                             logic [31:0] coef, logic [31:0] cand, logic [31:0] last);
        if (idle_in_enable) begin
            while ($urandom_range(99) < 16) begin
                cand_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        cand_if.valid         = 1'b1;
        cand_if.opcode        = op;
        cand_if.var_high      = vh[5:0];
        cand_if.var_low       = vl[4:0];
        cand_if.coef_word     = coef[15:0];
        cand_if.candidate     = cand;
        cand_if.last_of_batch = last[0];
        do @(posedge i_clk); while (!cand_if.ready);
        @(negedge i_clk);
        cand_if.valid = 1'b0;
        items_sent++;
    endtask

    // Wait for the chain to empty, then let its tail settle before a write
    task automatic drain_block();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg_index idx, logic [5:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic load_random_system(int density);
        for (int v = 0; v <= MAX_VARS; v++)
            send_item(OP_LIN, v, $urandom, ($urandom_range(99) < density) ? $urandom : 0,
                      $urandom, $urandom);
        for (int j = 1; j < MAX_VARS; j++)
            for (int k = 0; k < j; k++)
                if ($urandom_range(99) < 20)
                    send_item(OP_QUAD, j, k, ($urandom_range(99) < density) ? $urandom : 0,
                              $urandom, $urandom);
    endtask

    // Random candidate batch; many small candidates so sparse systems pass often
    task automatic send_batch(int len);
        logic [31:0] c;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
                0: c = 32'h0;
                1: c = $urandom & 32'h0000_000f;
                2: c = 32'h1 << $urandom_range(31);
                default: c = $urandom;
            endcase
            // Occasional mid-batch load or unused opcode as noise
            if ($urandom_range(99) < 3)
                send_item(OP_LIN, $urandom_range(40), $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(99) < 2)
                send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_item(OP_CAND, $urandom, $urandom, $urandom, c, 32'(i == len - 1));
        end
    endtask

    initial begin
        logic [5:0] nv_set [6] = '{6'd32, 6'd0, 6'd63, 6'd4, 6'd17, 6'd1};
        logic [5:0] mk_set [6] = '{6'd32, 6'd0, 6'd63, 6'd3, 6'd1, 6'd40};
        i_rst_n        = 1'b0;
        idle_in_enable = 1'b0;
        idle_out_enable = 1'b0;
        hold_off       = 1'b0;
        items_sent     = 0;
        cand_if.valid = 1'b0;  cand_if.opcode = OP_NONE; cand_if.var_high = '0;
        cand_if.var_low = '0;  cand_if.coef_word = '0;   cand_if.candidate = '0;
        cand_if.last_of_batch = 1'b0;
        cfg_if.valid = 1'b0;   cfg_if.index = REG_NUM_VARS; cfg_if.data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero system passes everything; then extremes and bad loads
        send_item(OP_CAND, 0, 0, 0, 32'h0, 0);
        send_item(OP_CAND, 0, 0, 0, 32'hffff_ffff, 1);
        send_item(OP_LIN, 0, 0, 32'hffff, 0, 0);          // constant term: all fail
        send_item(OP_LIN, 33, 0, 32'h0001, 0, 0);         // linear index out of range
        send_item(OP_LIN, 63, 0, 32'h0002, 0, 0);
        send_item(OP_QUAD, 5, 5, 32'hffff, 0, 0);         // k not below j
        send_item(OP_QUAD, 3, 7, 32'hffff, 0, 0);
        send_item(OP_QUAD, 32, 0, 32'hffff, 0, 0);        // j beyond last variable
        send_item(OP_NONE, 32'h3f, 32'h1f, 32'hffff, 32'hffff_ffff, 1);
        send_item(OP_CAND, 0, 0, 0, 32'h0, 1);
        send_item(OP_LIN, 32, 0, 32'hffff, 0, 0);         // x31 cancels constant
        send_item(OP_QUAD, 31, 30, 32'h8001, 0, 0);
        send_item(OP_QUAD, 1, 0, 32'h0f0f, 0, 0);
        send_item(OP_CAND, 0, 0, 0, 32'h8000_0000, 0);
        send_item(OP_CAND, 0, 0, 0, 32'hc000_0000, 1);
        // Batch overflow: 34 candidates with the constant cleared
        send_item(OP_LIN, 0, 0, 32'h0000, 0, 0);
        for (int i = 0; i < 34; i++)
            send_item(OP_CAND, 0, 0, 0, i, 32'(i == 33));
        drain_block();

        idle_in_enable  = 1'b1;
        idle_out_enable = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            write_register(REG_NUM_VARS, nv_set[phase]);
            write_register(REG_MAX_KEPT, mk_set[phase]);
            load_random_system(phase % 2 == 0 ? 15 : 40);
            // Phase 2: receiver stalls for a long stretch while input keeps coming
            if (phase == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            // Phase 3: no idling on either side
            idle_in_enable  = (phase != 3);
            idle_out_enable = (phase != 3);
            repeat (7) send_batch($urandom_range(1, 40));
            drain_block();
        end

        $display("ran %0d transactions, %0d results checked, %0d kept, across six settings",
                 items_sent, results_seen, kept_seen);
        if (fail_count == 0) begin
            $display("gf2_quadratic_candidate_filter_tb OK");
        end else begin
            $display("gf2_quadratic_candidate_filter_tb NOT OK");
        end
        $finish;
    end

endmodule
